// ===== rtl/lpe_pkg.sv =====
// Shared types, sizes and codes for the lifetime pool.
package lpe_pkg;

    localparam int POOL_DEPTH = 256;
    localparam int TIME_W     = 16;
    localparam int IDX_W      = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int CNT_W      = $clog2(POOL_DEPTH + 1);

    typedef logic [TIME_W-1:0] t_time;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [CNT_W-1:0]  t_cnt;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_SPAWN = 1'b1;

    typedef struct packed {
        logic        command;
        logic [15:0] tick_step;
        logic [15:0] spawn_life;
    } t_in;

    typedef struct packed {
        logic [8:0] live_count;
        logic [7:0] slot_written;
        logic       evicted;
        logic [8:0] removed_count;
    } t_out;

    typedef struct packed {
        t_time init_life;
        t_time rem_life;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [0:0] {
        ALU_AGE,
        ALU_ELAPSED
    } t_alu_op;

    typedef struct packed {
        t_time diff;
        logic  flag;
    } t_alu_res;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SPAWN,
        ST_SCAN,
        ST_SCAN_END,
        ST_EVICT,
        ST_TICK_RD,
        ST_TICK_CHK,
        ST_TICK_MOVE,
        ST_DONE
    } t_state;

endpackage

// ===== rtl/lpe_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lpe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                  i_wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/lpe_alu.sv =====
// Shared subtract-and-compare unit: ageing of an entry and elapsed-time compare.
module lpe_alu (
    input  lpe_pkg::t_alu_op  i_op,
    input  lpe_pkg::t_time    i_a,
    input  lpe_pkg::t_time    i_b,
    input  lpe_pkg::t_time    i_ref,
    output lpe_pkg::t_alu_res o_res
);

    lpe_pkg::t_time diff;

    always_comb begin
        diff       = i_a - i_b;
        o_res.diff = diff;
        case (i_op)
            lpe_pkg::ALU_AGE:     o_res.flag = (i_a <= i_b);
            lpe_pkg::ALU_ELAPSED: o_res.flag = (diff > i_ref);
            default:              o_res.flag = 1'b0;
        endcase
    end

endmodule

// ===== rtl/lifetime_pool_with_oldest_eviction_core.sv =====
// Lifetime pool top level: sequencer around the entry RAM and the shared ALU.
//
// Input channel (i_valid / o_stall, payload i_data): one beat is one command,
// a tick that ages every live entry or a spawn that stores a new one. Output
// channel (o_valid / i_stall, payload o_data): exactly one result beat per
// command, in command order.
// After the input beat is accepted: a spawn into a pool that is not full
// writes the next free slot; a spawn into a full pool first reads every
// entry, one RAM read per entry, while the oldest entry is searched, then
// overwrites that slot; a tick reads each live entry and then writes it
// back aged, or, if it expired, reads the last entry and writes it into
// that slot, which is then examined again.
// o_stall is high from acceptance until the result is loaded into the
// output register; one command is worked on at a time. A result held by
// i_stall stays on o_data; the next command may be accepted meanwhile but
// finishes only once the held beat has gone.
// Reset empties the pool and drops any pending result; entry storage is
// not cleared, as only slots below the live count are ever read.
module lifetime_pool_with_oldest_eviction_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  lpe_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output lpe_pkg::t_out o_data
);

    lpe_pkg::t_state   r_state, n_state;
    lpe_pkg::t_cnt     r_count, n_count;
    lpe_pkg::t_cnt     r_idx, n_idx;
    lpe_pkg::t_cnt     r_removed, n_removed;
    lpe_pkg::t_time    r_step, n_step;
    lpe_pkg::t_time    r_life, n_life;
    lpe_pkg::t_time    r_best, n_best;
    lpe_pkg::t_idx     r_slot, n_slot;
    lpe_pkg::t_idx     r_pick, n_pick;
    lpe_pkg::t_idx     r_pend_idx, n_pend_idx;
    logic              r_evict, n_evict;
    logic              r_have, n_have;
    logic              r_pend, n_pend;
    logic              r_out_vld, n_out_vld;
    lpe_pkg::t_out     r_out, n_out;

    logic                        ram_we;
    lpe_pkg::t_idx               ram_waddr;
    lpe_pkg::t_entry             ram_wdata;
    lpe_pkg::t_idx               ram_raddr;
    logic [lpe_pkg::ENTRY_W-1:0] ram_rdata;
    lpe_pkg::t_entry             rd_entry;

    lpe_pkg::t_alu_op  alu_op;
    lpe_pkg::t_time    alu_a;
    lpe_pkg::t_time    alu_b;
    lpe_pkg::t_alu_res alu_res;

    lpe_pkg::t_cnt     last_idx;
    logic              scanning;

    lpe_ram #(
        .WIDTH (lpe_pkg::ENTRY_W),
        .DEPTH (lpe_pkg::POOL_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_entry = lpe_pkg::t_entry'(ram_rdata);
    assign last_idx = r_count - 1'b1;
    assign scanning = (r_state == lpe_pkg::ST_SCAN) || (r_state == lpe_pkg::ST_SCAN_END);

    always_comb begin
        if (scanning) begin
            alu_op = lpe_pkg::ALU_ELAPSED;
            alu_a  = rd_entry.init_life;
            alu_b  = rd_entry.rem_life;
        end else begin
            alu_op = lpe_pkg::ALU_AGE;
            alu_a  = rd_entry.rem_life;
            alu_b  = r_step;
        end
    end

    lpe_alu u_alu (
        .i_op  (alu_op),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_ref (r_best),
        .o_res (alu_res)
    );

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        n_removed  = r_removed;
        n_step     = r_step;
        n_life     = r_life;
        n_best     = r_best;
        n_slot     = r_slot;
        n_pick     = r_pick;
        n_pend_idx = r_pend_idx;
        n_evict    = r_evict;
        n_have     = r_have;
        n_pend     = r_pend;
        n_out      = r_out;
        n_out_vld  = r_out_vld & i_stall;

        ram_we    = 1'b0;
        ram_waddr = r_idx[lpe_pkg::IDX_W-1:0];
        ram_wdata = '{init_life: r_life, rem_life: r_life};
        ram_raddr = r_idx[lpe_pkg::IDX_W-1:0];

        // fold the pending read into the running maximum of elapsed time
        if (scanning && r_pend && (!r_have || alu_res.flag)) begin
            n_best = alu_res.diff;
            n_pick = r_pend_idx;
            n_have = 1'b1;
        end

        case (r_state)
            lpe_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_step    = lpe_pkg::t_time'(i_data.tick_step);
                    n_life    = lpe_pkg::t_time'(i_data.spawn_life);
                    n_idx     = '0;
                    n_removed = '0;
                    n_slot    = '0;
                    n_evict   = 1'b0;
                    n_have    = 1'b0;
                    n_pend    = 1'b0;
                    if (i_data.command == lpe_pkg::CMD_SPAWN) begin
                        if (r_count < lpe_pkg::t_cnt'(lpe_pkg::POOL_DEPTH)) begin
                            n_state = lpe_pkg::ST_SPAWN;
                        end else begin
                            n_state = lpe_pkg::ST_SCAN;
                        end
                    end else begin
                        n_state = lpe_pkg::ST_TICK_RD;
                    end
                end
            end
            lpe_pkg::ST_SPAWN: begin
                ram_we    = 1'b1;
                ram_waddr = r_count[lpe_pkg::IDX_W-1:0];
                n_slot    = r_count[lpe_pkg::IDX_W-1:0];
                n_count   = r_count + 1'b1;
                n_state   = lpe_pkg::ST_DONE;
            end
            lpe_pkg::ST_SCAN: begin
                n_pend     = 1'b1;
                n_pend_idx = r_idx[lpe_pkg::IDX_W-1:0];
                n_idx      = r_idx + 1'b1;
                if (r_idx == last_idx) begin
                    n_state = lpe_pkg::ST_SCAN_END;
                end
            end
            lpe_pkg::ST_SCAN_END: begin
                n_pend  = 1'b0;
                n_state = lpe_pkg::ST_EVICT;
            end
            lpe_pkg::ST_EVICT: begin
                ram_we    = 1'b1;
                ram_waddr = r_pick;
                n_slot    = r_pick;
                n_evict   = 1'b1;
                n_state   = lpe_pkg::ST_DONE;
            end
            lpe_pkg::ST_TICK_RD: begin
                if (r_idx >= r_count) begin
                    n_state = lpe_pkg::ST_DONE;
                end else begin
                    n_state = lpe_pkg::ST_TICK_CHK;
                end
            end
            lpe_pkg::ST_TICK_CHK: begin
                if (alu_res.flag) begin
                    // expired: fetch the last entry to fill this slot
                    ram_raddr = last_idx[lpe_pkg::IDX_W-1:0];
                    n_state   = lpe_pkg::ST_TICK_MOVE;
                end else begin
                    ram_we    = 1'b1;
                    ram_wdata = '{init_life: rd_entry.init_life, rem_life: alu_res.diff};
                    n_idx     = r_idx + 1'b1;
                    n_state   = lpe_pkg::ST_TICK_RD;
                end
            end
            lpe_pkg::ST_TICK_MOVE: begin
                // moved entry is re-examined on the same index
                ram_we    = 1'b1;
                ram_wdata = rd_entry;
                n_count   = last_idx;
                n_removed = r_removed + 1'b1;
                n_state   = lpe_pkg::ST_TICK_RD;
            end
            lpe_pkg::ST_DONE: begin
                if (!r_out_vld || !i_stall) begin
                    n_out_vld           = 1'b1;
                    n_out.live_count    = 9'(r_count);
                    n_out.slot_written  = 8'(r_slot);
                    n_out.evicted       = r_evict;
                    n_out.removed_count = 9'(r_removed);
                    n_state             = lpe_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lpe_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= lpe_pkg::ST_IDLE;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_removed  <= n_removed;
        r_step     <= n_step;
        r_life     <= n_life;
        r_best     <= n_best;
        r_slot     <= n_slot;
        r_pick     <= n_pick;
        r_pend_idx <= n_pend_idx;
        r_evict    <= n_evict;
        r_have     <= n_have;
        r_pend     <= n_pend;
        r_out      <= n_out;
    end

    assign o_stall = (r_state != lpe_pkg::ST_IDLE);
    assign o_valid = r_out_vld;
    assign o_data  = r_out;

endmodule

// ===== rtl/lpe_checker.sv =====
// Port-level checks for the lifetime pool, bound to the top level.
module lpe_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_stall,
    input lpe_pkg::t_in  i_data,
    input logic          o_valid,
    input logic          i_stall,
    input lpe_pkg::t_out o_data
);

    // a held result beat keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("result beat changed while stalled");

    // an accepted command keeps the input side closed on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not stalled after an accepted beat");

    // eviction only happens with the pool full
    a_evict_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.evicted |->
            o_data.live_count == 9'(lpe_pkg::POOL_DEPTH))
        else $error("eviction reported with pool not full");

    // a tick that removed entries reports no slot and no eviction
    a_tick_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.removed_count != 9'd0) |->
            (o_data.slot_written == 8'd0) && !o_data.evicted)
        else $error("removal reported together with spawn fields");

endmodule

bind lifetime_pool_with_oldest_eviction_core lpe_checker u_lpe_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

// ===== dv/pool_score_pkg.sv =====
// Scoreboard class for the lifetime pool: predicts each result beat and checks the DUT against it.
package pool_score_pkg;

    import lpe_pkg::*;

    class pool_scoreboard;

        t_time       rem_life  [POOL_DEPTH];
        t_time       init_life [POOL_DEPTH];
        int unsigned live;
        t_out        pending[$];
        int unsigned errors;

        function new();
            live   = 0;
            errors = 0;
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH %s", msg);
            errors++;
        endtask

        // Lowest index wins on equal elapsed time.
        function int unsigned oldest_slot();
            int unsigned pick;
            int unsigned i;
            t_time       best;
            t_time       elapsed;
            pick = 0;
            best = '0;
            for (i = 0; i < live; i++) begin
                elapsed = init_life[i] - rem_life[i];
                if (i == 0 || elapsed > best) begin
                    best = elapsed;
                    pick = i;
                end
            end
            return pick;
        endfunction

        function void note_command(t_in cmd);
            t_out        res;
            int unsigned idx;
            int unsigned removed;
            res     = '0;
            removed = 0;
            if (cmd.command == CMD_SPAWN) begin
                if (live < POOL_DEPTH) begin
                    idx = live;
                    live++;
                end else begin
                    idx         = oldest_slot();
                    res.evicted = 1'b1;
                end
                rem_life[idx]    = cmd.spawn_life;
                init_life[idx]   = cmd.spawn_life;
                res.slot_written = 8'(idx);
            end else begin
                idx = 0;
                while (idx < live) begin
                    if (rem_life[idx] <= cmd.tick_step) begin
                        // move the last entry in and look at this slot again
                        rem_life[idx]  = rem_life[live-1];
                        init_life[idx] = init_life[live-1];
                        live--;
                        removed++;
                    end else begin
                        rem_life[idx] = rem_life[idx] - cmd.tick_step;
                        idx++;
                    end
                end
                res.removed_count = 9'(removed);
            end
            res.live_count = 9'(live);
            pending.push_back(res);
        endfunction

        task check_result(t_out got);
            t_out want;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected beat count=%0d slot=%0d ev=%0d rm=%0d",
                    got.live_count, got.slot_written, got.evicted, got.removed_count));
                return;
            end
            want = pending.pop_front();
            if (got.live_count !== want.live_count)
                report_mismatch($sformatf("live_count got %0d want %0d",
                    got.live_count, want.live_count));
            if (got.slot_written !== want.slot_written)
                report_mismatch($sformatf("slot_written got %0d want %0d",
                    got.slot_written, want.slot_written));
            if (got.evicted !== want.evicted)
                report_mismatch($sformatf("evicted got %0d want %0d",
                    got.evicted, want.evicted));
            if (got.removed_count !== want.removed_count)
                report_mismatch($sformatf("removed_count got %0d want %0d",
                    got.removed_count, want.removed_count));
        endtask

    endclass

endpackage

// ===== dv/tb.sv =====
// Top-level testbench for the lifetime pool: clock, reset, beat drivers, monitor and run control.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import lpe_pkg::*;
    import pool_score_pkg::*;

    logic  i_clk   = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_valid = 1'b0;
    logic  i_stall = 1'b0;
    t_in   i_data  = '0;
    logic  o_stall;
    logic  o_valid;
    t_out  o_data;

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    int unsigned beats_sent    = 0;
    logic        hold_off      = 1'b0;

    pool_scoreboard sb;

    always #10 i_clk = ~i_clk;

    lifetime_pool_with_oldest_eviction_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    // Offer one command beat; called and returns at a falling edge.
    task automatic send_beat(input t_in beat);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= beat;
        do @(posedge i_clk); while (o_stall);
        sb.note_command(beat);
        beats_sent++;
        @(negedge i_clk);
    endtask

    task automatic age_pool(input t_time step);
        t_in beat;
        beat.command    = CMD_TICK;
        beat.tick_step  = step;
        beat.spawn_life = 16'($urandom);
        send_beat(beat);
    endtask

    task automatic spawn_entry(input t_time life);
        t_in beat;
        beat.command    = CMD_SPAWN;
        beat.tick_step  = 16'($urandom);
        beat.spawn_life = life;
        send_beat(beat);
    endtask

    function automatic t_in random_command(input int unsigned spawn_pct,
                                           input int unsigned flush_pct);
        t_in         beat;
        int unsigned roll;
        beat.command = ($urandom_range(99) < spawn_pct) ? CMD_SPAWN : CMD_TICK;
        roll = $urandom_range(99);
        if (roll < 8)
            beat.tick_step = '0;
        else if (roll < 8 + flush_pct)
            beat.tick_step = 16'($urandom);
        else
            beat.tick_step = 16'($urandom_range(255));
        roll = $urandom_range(99);
        if (roll < 4)
            beat.spawn_life = '0;
        else if (roll < 10)
            beat.spawn_life = 16'hFFFF;
        else if (roll < 15)
            beat.spawn_life = 16'($urandom_range(64, 1));
        else
            beat.spawn_life = 16'($urandom_range(65535, 1024));
        return beat;
    endfunction

    always @(negedge i_clk)
        i_stall <= hold_off || ($urandom_range(99) < stall_pct);

    always @(posedge i_clk)
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_data);

    // Long receiver hold-off so the pool backs up and stalls its input.
    initial begin
        wait (beats_sent >= 60);
        @(posedge i_clk);
        hold_off = 1'b1;
        repeat (2000) @(posedge i_clk);
        hold_off = 1'b0;
    end

    initial begin
        #100ms;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int unsigned phase;
        int unsigned phase_beats;
        bit          fill;
        sb = new();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty pool, both step extremes
        age_pool(16'h0000);
        age_pool(16'hFFFF);
        // zero life expires even on a zero step
        spawn_entry(16'h0000);
        age_pool(16'h0000);
        spawn_entry(16'hFFFF);
        spawn_entry(16'h0001);
        spawn_entry(16'h8000);
        spawn_entry(16'h7FFF);
        // life equal to step expires; last entry moves in and is re-examined
        age_pool(16'h0001);
        age_pool(16'h0000);
        spawn_entry(16'h5555);
        spawn_entry(16'hAAAA);
        age_pool(16'h7FFF);
        spawn_entry(16'h0000);
        spawn_entry(16'h0000);
        // flush everything
        age_pool(16'hFFFF);

        // even phases fill the pool and evict; odd phases churn with big steps
        for (phase = 0; phase < 4; phase++) begin
            fill = (phase % 2 == 0);
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    send_idle_pct = 55;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 55;
                end
                default: begin
                    send_idle_pct = 31;
                    stall_pct     = 31;
                end
            endcase
            phase_beats = fill ? 300 : 250;
            repeat (phase_beats)
                send_beat(random_command(fill ? 96 : 62, fill ? 0 : 12));
        end
        i_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (800) @(posedge i_clk);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
